[sv/itcf_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the tilt filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package itcf_pkg;
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int TABLE_FRAC      = 24;
   localparam int IN_W            = 16;
   localparam int OUT_W           = 26;
   localparam int SCALE_W         = 24;
   localparam int WEIGHT_W        = 17;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 24;
   localparam int VEC_W           = 32;
   localparam int ZW              = 36;
   localparam int ANG_W           = ANGLE_FRAC_BITS + 10;

   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_STEP_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_WEIGHT     = 2'd1;

   localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd262144;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd62259;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;

   typedef struct packed {
      logic signed [IN_W-1:0] accel_x;
      logic signed [IN_W-1:0] accel_y;
      logic signed [IN_W-1:0] accel_z;
      logic signed [IN_W-1:0] rate_x;
      logic signed [IN_W-1:0] rate_y;
      logic signed [IN_W-1:0] rate_z;
   } sample_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  step_scale;
      logic [WEIGHT_W-1:0] weight;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } cordic_stat_type;

   // atan(2^-i) in 2^-24 degree
   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:  v = 36'sd754974720;
         5'd1:  v = 36'sd445687602;
         5'd2:  v = 36'sd235489089;
         5'd3:  v = 36'sd119537938;
         5'd4:  v = 36'sd60000934;
         5'd5:  v = 36'sd30029717;
         5'd6:  v = 36'sd15018523;
         5'd7:  v = 36'sd7509720;
         5'd8:  v = 36'sd3754917;
         5'd9:  v = 36'sd1877466;
         5'd10: v = 36'sd938734;
         5'd11: v = 36'sd469367;
         5'd12: v = 36'sd234684;
         5'd13: v = 36'sd117342;
         5'd14: v = 36'sd58671;
         5'd15: v = 36'sd29335;
         5'd16: v = 36'sd14668;
         5'd17: v = 36'sd7334;
         5'd18: v = 36'sd3667;
         5'd19: v = 36'sd1833;
         5'd20: v = 36'sd917;
         5'd21: v = 36'sd458;
         5'd22: v = 36'sd229;
         5'd23: v = 36'sd115;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

[sv/itcf_queue.sv]
// Front end: two-word sample queue between the request port and the engine.
// Depends on itcf_pkg.
`timescale 1ns / 1ps
module itcf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  itcf_pkg::sample_type req_word,
   input  logic                pop,
   output logic                q_valid,
   output itcf_pkg::sample_type q_word
);
   import itcf_pkg::*;

   sample_type  mem_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, take;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign take      = pop && q_valid;
   assign q_word    = mem_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !take) cnt_in = cnt_ff + 2'd1;
      else if (take && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (take) rd_ptr_ff <= ~rd_ptr_ff;
      end
      if (push) mem_ff[wr_ptr_ff] <= req_word;
   end
endmodule

[sv/itcf_cordic.sv]
// Iterative vectoring CORDIC: atan2(y, x) in degrees, one micro-rotation a cycle.
// Depends on itcf_pkg (step count, table, widths).
`timescale 1ns / 1ps
module itcf_cordic (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [itcf_pkg::VEC_W-1:0] x_in,
   input  logic signed [itcf_pkg::VEC_W-1:0] y_in,
   output itcf_pkg::cordic_stat_type     stat,
   output logic signed [itcf_pkg::ANG_W-1:0] angle
);
   import itcf_pkg::*;

   localparam int CNT_W = (CORDIC_STEPS > 16) ? 5 : 4;
   localparam int RS    = TABLE_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [ZW-1:0] HALF_Z  = ZW'(180) <<< TABLE_FRAC;
   localparam logic signed [ZW-1:0] ROUND_Z = ZW'(1) <<< (RS - 1);

   logic signed [VEC_W-1:0] x_ff, y_ff, dx, dy;
   logic signed [ZW-1:0]    z_ff, rnd;
   logic [CNT_W-1:0]        i_ff;
   logic                    busy_ff, done_ff, zero_ff;

   assign dx  = y_ff >>> i_ff;
   assign dy  = x_ff >>> i_ff;
   assign rnd = (z_ff + ROUND_Z) >>> RS;
   assign angle = zero_ff ? '0 : rnd[ANG_W-1:0];
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && i_ff == CNT_W'(CORDIC_STEPS - 1)) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
      if (start) begin
         i_ff    <= '0;
         zero_ff <= (x_in == '0) && (y_in == '0);
         // left half-plane: pre-rotate by 180 degrees
         if (x_in < 0) begin
            z_ff <= (y_in >= 0) ? HALF_Z : -HALF_Z;
            x_ff <= -x_in;
            y_ff <= -y_in;
         end else begin
            z_ff <= '0;
            x_ff <= x_in;
            y_ff <= y_in;
         end
      end else if (busy_ff) begin
         i_ff <= i_ff + 1'b1;
         if (y_ff > 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_entry(5'(i_ff));
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_entry(5'(i_ff));
         end
      end
   end
endmodule

[sv/itcf_engine.sv]
// Back end: hypot root, CORDIC sequencing, gyro integration, blend and output word.
// Depends on itcf_pkg and itcf_cordic.
`timescale 1ns / 1ps
module itcf_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  itcf_pkg::cfg_type            cfg,
   input  logic                         q_valid,
   input  itcf_pkg::sample_type         q_word,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [itcf_pkg::OUT_W-1:0] roll_deg,
   output logic signed [itcf_pkg::OUT_W-1:0] pitch_deg,
   output logic signed [itcf_pkg::OUT_W-1:0] yaw_deg
);
   import itcf_pkg::*;

   localparam int RW       = 57;
   localparam int ROOT_TOP = 54;
   localparam int PROD_W   = IN_W + SCALE_W + 1;
   localparam int INC_SH   = 32 - ANGLE_FRAC_BITS;
   localparam int G_W      = OUT_W + 1;
   localparam int BL_W     = 48;
   localparam logic signed [PROD_W-1:0] INC_RND = PROD_W'(1) <<< (INC_SH - 1);
   localparam logic signed [BL_W-1:0]  LIM  = BL_W'(360) <<< ANGLE_FRAC_BITS;
   localparam logic signed [G_W-1:0]   HALF = G_W'(180) <<< ANGLE_FRAC_BITS;
   localparam logic signed [G_W-1:0]   FULL = G_W'(360) <<< ANGLE_FRAC_BITS;
   localparam logic signed [BL_W-1:0]  BL_RND = BL_W'(32768);

   typedef enum logic [3:0] {
      S_IDLE, S_SQX, S_SQZ, S_ROOT, S_PITCH, S_PWAIT, S_GX, S_BR1, S_BR2, S_BR3,
      S_GY, S_BP1, S_BP2, S_BP3, S_GZ, S_OUT
   } state_type;

   state_type state_ff, state_in;
   sample_type smp_ff;
   logic [32:0]   sq_ff;
   logic [RW-1:0] v_ff, r_ff, b_ff, rb;
   logic          ge;
   logic signed [ANG_W-1:0] acc_roll_ff, acc_pitch_ff, cangle;
   logic signed [G_W-1:0]   g_ff, gsum, ysum;
   logic signed [BL_W-1:0]  p1_ff, p2_ff, bsum, bsat;
   logic signed [OUT_W-1:0] roll_st_ff, pitch_st_ff, yaw_st_ff, base;
   logic signed [OUT_W-1:0] roll_out_ff, pitch_out_ff, yaw_out_ff;
   logic signed [IN_W-1:0]  rate;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] incr;
   logic [WEIGHT_W-1:0]     w;
   logic signed [WEIGHT_W:0] w_s, wc_s;
   logic signed [VEC_W-1:0] cx, cy;
   logic [32:0]             sqz;
   logic                    cstart, load, rsp_valid_ff, rsp_valid_in;
   cordic_stat_type         cstat;

   itcf_cordic u_cordic (
      .clock (clock), .reset (reset), .start (cstart),
      .x_in  (cx), .y_in (cy), .stat (cstat), .angle (cangle)
   );

   assign cstart = (state_ff == S_SQX) || (state_ff == S_PITCH);
   always_comb begin
      if (state_ff == S_PITCH) begin
         cx = $signed({1'b0, r_ff[VEC_W-2:0]});
         cy = VEC_W'(smp_ff.accel_y) <<< 12;
      end else begin
         cx = VEC_W'(smp_ff.accel_z) <<< 12;
         cy = -(VEC_W'(smp_ff.accel_x) <<< 12);
      end
   end

   // bit-pair square root, one result bit a cycle
   assign rb = r_ff + b_ff;
   assign ge = v_ff >= rb;
   assign sqz = sq_ff + 33'(unsigned'(32'(smp_ff.accel_z * smp_ff.accel_z)));

   always_comb begin
      case (state_ff)
         S_GX:    begin rate = smp_ff.rate_x; base = roll_st_ff; end
         S_GY:    begin rate = smp_ff.rate_y; base = pitch_st_ff; end
         default: begin rate = smp_ff.rate_z; base = yaw_st_ff; end
      endcase
   end
   assign prod = rate * $signed({1'b0, cfg.step_scale});
   assign incr = (prod + INC_RND) >>> INC_SH;
   assign gsum = G_W'(base) + incr[G_W-1:0];
   assign ysum = (gsum > HALF) ? gsum - FULL : (gsum < -HALF) ? gsum + FULL : gsum;

   assign w    = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;
   assign w_s  = $signed({1'b0, w});
   assign wc_s = $signed({1'b0, WEIGHT_ONE - w});
   assign bsum = (p1_ff + p2_ff + BL_RND) >>> 16;
   assign bsat = (bsum > LIM) ? LIM : (bsum < -LIM) ? -LIM : bsum;

   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (q_valid) state_in = S_SQX;
         S_SQX:   state_in = S_SQZ;
         S_SQZ:   state_in = S_ROOT;
         S_ROOT:  if (b_ff == '0 && cstat.done) state_in = S_PITCH;
         S_PITCH: state_in = S_PWAIT;
         S_PWAIT: if (cstat.done) state_in = S_GX;
         S_GX:    state_in = S_BR1;
         S_BR1:   state_in = S_BR2;
         S_BR2:   state_in = S_BR3;
         S_BR3:   state_in = S_GY;
         S_GY:    state_in = S_BP1;
         S_BP1:   state_in = S_BP2;
         S_BP2:   state_in = S_BP3;
         S_BP3:   state_in = S_GZ;
         S_GZ:    state_in = S_OUT;
         S_OUT:   if (load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         roll_st_ff   <= '0;
         pitch_st_ff  <= '0;
         yaw_st_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_BR3:   roll_st_ff  <= bsat[OUT_W-1:0];
            S_BP3:   pitch_st_ff <= bsat[OUT_W-1:0];
            S_GZ:    yaw_st_ff   <= ysum[OUT_W-1:0];
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: smp_ff <= q_word;
         S_SQX:  sq_ff  <= 33'(unsigned'(32'(smp_ff.accel_x * smp_ff.accel_x)));
         S_SQZ: begin
            v_ff <= RW'(sqz) << 24;
            r_ff <= '0;
            b_ff <= RW'(1) << ROOT_TOP;
         end
         S_ROOT: begin
            if (b_ff != '0) begin
               if (ge) begin
                  v_ff <= v_ff - rb;
                  r_ff <= (r_ff >> 1) + b_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               b_ff <= b_ff >> 2;
            end
            acc_roll_ff <= cangle;
         end
         S_PWAIT: acc_pitch_ff <= cangle;
         S_GX, S_GY: g_ff <= gsum;
         S_BR1, S_BP1: p1_ff <= w_s * g_ff;
         S_BR2: p2_ff <= wc_s * acc_roll_ff;
         S_BP2: p2_ff <= wc_s * acc_pitch_ff;
         default: ;
      endcase
      if (load) begin
         roll_out_ff  <= roll_st_ff;
         pitch_out_ff <= pitch_st_ff;
         yaw_out_ff   <= yaw_st_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign roll_deg  = roll_out_ff;
   assign pitch_deg = pitch_out_ff;
   assign yaw_deg   = yaw_out_ff;

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (BL_W'(roll_out_ff) <= LIM) && (BL_W'(roll_out_ff) >= -LIM))
      else $error("roll word out of saturation range");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (BL_W'(pitch_out_ff) <= LIM) && (BL_W'(pitch_out_ff) >= -LIM))
      else $error("pitch word out of saturation range");
   a_yaw_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (G_W'(yaw_out_ff) <= HALF) && (G_W'(yaw_out_ff) >= -HALF))
      else $error("yaw word not wrapped");
   a_pitch_after_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PITCH) |-> $past(cstat.done) && (b_ff == '0))
      else $error("pitch CORDIC started before root finished");
endmodule

[sv/imu_tilt_complementary_filter.sv]
// Top level: roll/pitch/yaw complementary filter with config registers.
// Each accepted req word runs a 28-step root of ax^2+az^2 with the roll CORDIC
// beside it, then 16 pitch CORDIC steps, before its rsp word is loaded.
// The engine works on one sample at a time, held by the root and CORDIC loops;
// a two-word queue takes samples while the engine works. Reset (synchronous)
// zeros the angles and restores gyro_step_scale and gyro_weight defaults.
`timescale 1ns / 1ps
module imu_tilt_complementary_filter (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_x,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_y,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_z,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_x,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_y,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [itcf_pkg::OUT_W-1:0] rsp_roll_deg,
   output logic signed [itcf_pkg::OUT_W-1:0] rsp_pitch_deg,
   output logic signed [itcf_pkg::OUT_W-1:0] rsp_yaw_deg,
   input  logic csr_wr_en,
   input  logic [itcf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [itcf_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import itcf_pkg::*;

   cfg_type    cfg_ff;
   sample_type req_word, q_word;
   logic       q_valid, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_scale <= SCALE_RESET;
         cfg_ff.weight     <= WEIGHT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GYRO_STEP_SCALE: cfg_ff.step_scale <= csr_wdata[SCALE_W-1:0];
            CSR_GYRO_WEIGHT:     cfg_ff.weight     <= csr_wdata[WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_word.accel_x = req_accel_x;
   assign req_word.accel_y = req_accel_y;
   assign req_word.accel_z = req_accel_z;
   assign req_word.rate_x  = req_rate_x;
   assign req_word.rate_y  = req_rate_y;
   assign req_word.rate_z  = req_rate_z;

   itcf_queue u_queue (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_stall (req_stall), .req_word (req_word),
      .pop (q_pop), .q_valid (q_valid), .q_word (q_word)
   );

   itcf_engine u_engine (
      .clock (clock), .reset (reset), .cfg (cfg_ff),
      .q_valid (q_valid), .q_word (q_word), .q_pop (q_pop),
      .rsp_valid (rsp_valid), .rsp_stall (rsp_stall),
      .roll_deg (rsp_roll_deg), .pitch_deg (rsp_pitch_deg), .yaw_deg (rsp_yaw_deg)
   );
endmodule

[test/itcf_checker.sv]
// Checker for the tilt filter: watches req/rsp words, predicts fused angles,
// compares each rsp word against the oldest prediction. Depends on itcf_pkg.
`timescale 1ns / 1ps
module itcf_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_x,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_y,
   input  logic signed [itcf_pkg::IN_W-1:0] req_accel_z,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_x,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_y,
   input  logic signed [itcf_pkg::IN_W-1:0] req_rate_z,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic signed [itcf_pkg::OUT_W-1:0] rsp_roll_deg,
   input  logic signed [itcf_pkg::OUT_W-1:0] rsp_pitch_deg,
   input  logic signed [itcf_pkg::OUT_W-1:0] rsp_yaw_deg,
   input  logic csr_wr_en,
   input  logic [itcf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [itcf_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int fail_count,
   output int pending
);
   import itcf_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] roll;
      logic signed [OUT_W-1:0] pitch;
      logic signed [OUT_W-1:0] yaw;
   } angles_type;

   angles_type angle_queue[$];
   longint roll_q, pitch_q, yaw_q;
   logic [SCALE_W-1:0] step_scale;
   logic [WEIGHT_W-1:0] weight;

   assign pending = angle_queue.size();

   // arithmetic shift of a signed value rounds toward -inf
   function automatic longint arctan_deg(input longint y, input longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? (longint'(180) <<< TABLE_FRAC) : -(longint'(180) <<< TABLE_FRAC);
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(atan_entry(i[4:0]));
         end else begin
            x -= dx; y += dy; z -= longint'(atan_entry(i[4:0]));
         end
      end
      return (z + (longint'(1) <<< (TABLE_FRAC - ANGLE_FRAC_BITS - 1)))
             >>> (TABLE_FRAC - ANGLE_FRAC_BITS);
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint rate_step(input longint rate);
      return (rate * longint'(step_scale) + (longint'(1) <<< (31 - ANGLE_FRAC_BITS)))
             >>> (32 - ANGLE_FRAC_BITS);
   endfunction

   function automatic longint fuse(input longint g, input longint a);
      longint w, v, lim;
      w = (weight > WEIGHT_ONE) ? 65536 : longint'(weight);
      v = (w * g + (65536 - w) * a + 32768) >>> 16;
      lim = longint'(360) <<< ANGLE_FRAC_BITS;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return v;
   endfunction

   task automatic predict_angles();
      longint ax, ay, az, acc_roll, acc_pitch, y;
      longint half, full;
      angles_type e;
      ax = req_accel_x; ay = req_accel_y; az = req_accel_z;
      half = longint'(180) <<< ANGLE_FRAC_BITS;
      full = longint'(360) <<< ANGLE_FRAC_BITS;
      acc_roll = arctan_deg(-ax * 4096, az * 4096);
      acc_pitch = arctan_deg(ay * 4096, root_floor((ax * ax + az * az) << 24));
      roll_q = fuse(roll_q + rate_step(req_rate_x), acc_roll);
      pitch_q = fuse(pitch_q + rate_step(req_rate_y), acc_pitch);
      y = yaw_q + rate_step(req_rate_z);
      if (y > half) y -= full;
      else if (y < -half) y += full;
      yaw_q = y;
      e.roll = roll_q[OUT_W-1:0];
      e.pitch = pitch_q[OUT_W-1:0];
      e.yaw = yaw_q[OUT_W-1:0];
      angle_queue.push_back(e);
   endtask

   always @(posedge clock) begin
      angles_type e;
      if (reset) begin
         roll_q = 0; pitch_q = 0; yaw_q = 0;
         step_scale = SCALE_RESET;
         weight = WEIGHT_RESET;
         angle_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_GYRO_STEP_SCALE) step_scale = csr_wdata[SCALE_W-1:0];
            else if (csr_index == CSR_GYRO_WEIGHT) weight = csr_wdata[WEIGHT_W-1:0];
         end
         if (req_valid && !req_stall) predict_angles();
         if (rsp_valid && !rsp_stall) begin
            if (angle_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected rsp word at %0t", $time);
               fail_count <= fail_count + 1;
            end else begin
               e = angle_queue.pop_front();
               if (e.roll !== rsp_roll_deg || e.pitch !== rsp_pitch_deg ||
                   e.yaw !== rsp_yaw_deg) begin
                  if (fail_count < 10)
                     $display("mismatch at %0t: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                              $time, e.roll, rsp_roll_deg, e.pitch, rsp_pitch_deg,
                              e.yaw, rsp_yaw_deg);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[test/tb_imu_tilt_complementary_filter.sv]
// Testbench top for the tilt filter: clock, reset, stimulus and verdict.
// Depends on itcf_pkg, the block and itcf_checker.
`timescale 1ns / 1ps
module tb_imu_tilt_complementary_filter;
   import itcf_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [IN_W-1:0] ax = 0, ay = 0, az = 0, gx = 0, gy = 0, gz = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [OUT_W-1:0] roll, pitch, yaw;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GYRO_STEP_SCALE;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;
   int fail_count, pending;
   int send_idle = 0, recv_idle = 0;

   always #2 clock = ~clock;

   imu_tilt_complementary_filter dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_accel_x(ax), .req_accel_y(ay), .req_accel_z(az),
      .req_rate_x(gx), .req_rate_y(gy), .req_rate_z(gz),
      .rsp_valid, .rsp_stall,
      .rsp_roll_deg(roll), .rsp_pitch_deg(pitch), .rsp_yaw_deg(yaw),
      .csr_wr_en, .csr_index, .csr_wdata);

   itcf_checker chk (
      .clock, .reset, .req_valid, .req_stall,
      .req_accel_x(ax), .req_accel_y(ay), .req_accel_z(az),
      .req_rate_x(gx), .req_rate_y(gy), .req_rate_z(gz),
      .rsp_valid, .rsp_stall,
      .rsp_roll_deg(roll), .rsp_pitch_deg(pitch), .rsp_yaw_deg(yaw),
      .csr_wr_en, .csr_index, .csr_wdata, .fail_count, .pending);

   // receiver stall, redrawn each falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle);

   // valid stays high after the word is taken; the next call clears it or drives a
   // new word, and csr_write or an explicit drop clears it
   task automatic send_word(input logic [15:0] a, b, c, d, e, f);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      ax <= a; ay <= b; az <= c; gx <= d; gy <= e; gz <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [23:0] v);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (80) @(negedge clock);
      csr_wr_en <= 1; csr_index <= idx; csr_wdata <= v;
      @(negedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic random_burst(input int n);
      for (int i = 0; i < n; i++)
         send_word(pick_axis(), pick_axis(), pick_axis(),
                   pick_axis(), pick_axis(), pick_axis());
   endtask

   initial begin
      #4000000;
      $display("imu_tilt_complementary_filter verification failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);
      // directed: zero vector, axis extremes, roll vector on its axes and in quadrants two to four
      send_word(0, 0, 0, 0, 0, 0);
      send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_word(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_word(0, 0, 16'h8000, 0, 0, 0);
      send_word(0, 16'h8000, 16'h8000, 0, 0, 0);
      send_word(16'h0001, 0, 16'hffff, 0, 0, 0);
      send_word(16'hffff, 0, 16'hffff, 0, 0, 0);
      send_word(16'h1000, 16'hf000, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++)
         send_word(0, 0, 16'h4000, 16'h7fff, 16'h7fff, 16'h7fff);
      // max scale: yaw wrap and roll/pitch saturation
      csr_write(CSR_GYRO_STEP_SCALE, 24'hffffff);
      csr_write(CSR_GYRO_WEIGHT, 24'd65536);
      for (int i = 0; i < 6; i++)
         send_word(16'h8000, 16'h7fff, 0, 16'h8000, 16'h7fff, 16'h8000);
      send_word(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
      csr_write(CSR_GYRO_WEIGHT, 24'h1ffff);
      send_word(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);

      send_idle = 24; recv_idle = 87;
      csr_write(CSR_GYRO_WEIGHT, 0);
      csr_write(CSR_GYRO_STEP_SCALE, 0);
      random_burst(200);
      csr_write(CSR_GYRO_WEIGHT, 24'(WEIGHT_RESET));
      csr_write(CSR_GYRO_STEP_SCALE, SCALE_RESET);
      random_burst(400);
      send_idle = 87; recv_idle = 24;
      csr_write(CSR_GYRO_WEIGHT, 24'($urandom_range(65536)));
      csr_write(CSR_GYRO_STEP_SCALE, 24'($urandom));
      random_burst(550);
      send_idle = 0; recv_idle = 0;
      csr_write(CSR_GYRO_WEIGHT, 24'd32768);
      csr_write(CSR_GYRO_STEP_SCALE, 24'hffffff);
      random_burst(600);
      req_valid <= 0;

      while (pending != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (fail_count == 0)
         $display("imu_tilt_complementary_filter verification clean");
      else
         $display("imu_tilt_complementary_filter verification failed");
      $finish;
   end
endmodule

[files.f]
sv/itcf_pkg.sv
sv/itcf_queue.sv
sv/itcf_cordic.sv
sv/itcf_engine.sv
sv/imu_tilt_complementary_filter.sv
test/itcf_checker.sv
test/tb_imu_tilt_complementary_filter.sv
